FILE: rtl/mft_pkg.sv
package mft_pkg;

   // Motor identifiers start here; motor k answers on ID_BASE + k.
   localparam logic [10:0] ID_BASE = 11'h201;

   // One turn of the encoder is 8192 counts; half a turn marks a wrap.
   localparam int TURN_SHIFT = 13;
   localparam logic signed [16:0] HALF_TURN = 17'sd4096;

   // Timeout register value after reset, in milliseconds.
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;

   // Default number of tracked motors.
   localparam int DEFAULT_NUM_MOTORS = 4;

   // Operation codes carried on the request tuser.
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // Command from the top level to one motor slot for the item in flight.
   typedef struct packed {
      logic        frame_hit;
      logic        check;
      logic [31:0] now_ms;
      logic [15:0] position;
      logic [15:0] speed;
      logic [15:0] current;
   } slot_cmd_type;

   // Entry of one motor slot as it stands after the item in flight.
   typedef struct packed {
      logic        online;
      logic [15:0] position;
      logic [15:0] speed;
      logic [15:0] current;
      logic [31:0] total;
   } slot_view_type;

endpackage

FILE: rtl/mft_motor_slot.sv
module mft_motor_slot
   import mft_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          apply,
   input  slot_cmd_type  cmd,
   input  logic [15:0]   timeout_ms,
   output slot_view_type view
);

   logic [15:0] last_position_ff, last_position_in;
   logic [31:0] turn_count_ff, turn_count_in;
   logic [31:0] last_seen_ff, last_seen_in;
   logic        online_ff, online_in;
   logic [15:0] speed_ff, speed_in;
   logic [15:0] current_ff, current_in;
   logic [31:0] total_ff, total_in;

   logic signed [16:0] diff;
   logic [31:0]        age;
   logic               expired;

   // Position jump and age of this motor's entry.
   assign diff    = $signed({1'b0, cmd.position}) - $signed({1'b0, last_position_ff});
   assign age     = cmd.now_ms - last_seen_ff;
   assign expired = age > {16'd0, timeout_ms};

   // Next entry: a frame refreshes it and unwraps the turn, a check ages it.
   always_comb begin
      last_position_in = last_position_ff;
      turn_count_in    = turn_count_ff;
      last_seen_in     = last_seen_ff;
      online_in        = online_ff;
      speed_in         = speed_ff;
      current_in       = current_ff;
      total_in         = total_ff;
      if (cmd.frame_hit) begin
         if (diff > HALF_TURN) begin
            turn_count_in = turn_count_ff - 32'd1;
         end else if (diff < -HALF_TURN) begin
            turn_count_in = turn_count_ff + 32'd1;
         end
         last_position_in = cmd.position;
         last_seen_in     = cmd.now_ms;
         online_in        = 1'b1;
         speed_in         = cmd.speed;
         current_in       = cmd.current;
         total_in         = (turn_count_in << TURN_SHIFT) + {16'd0, cmd.position};
      end else if (cmd.check && expired) begin
         online_in = 1'b0;
         speed_in  = 16'd0;
      end
   end

   // The report shows the entry as it is after this item.
   assign view.online   = online_in;
   assign view.position = last_position_in;
   assign view.speed    = speed_in;
   assign view.current  = current_in;
   assign view.total    = total_in;

   // Entry registers, all cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff <= 16'd0;
         turn_count_ff    <= 32'd0;
         last_seen_ff     <= 32'd0;
         online_ff        <= 1'b0;
         speed_ff         <= 16'd0;
         current_ff       <= 16'd0;
         total_ff         <= 32'd0;
      end else if (apply) begin
         last_position_ff <= last_position_in;
         turn_count_ff    <= turn_count_in;
         last_seen_ff     <= last_seen_in;
         online_ff        <= online_in;
         speed_ff         <= speed_in;
         current_ff       <= current_in;
         total_ff         <= total_in;
      end
   end

endmodule

FILE: rtl/motor_feedback_multiturn_tracker_unit.sv
// Path: the input register, then the result register; the result of a request is valid once it
// has moved from the input register into the result register.
// Throughput: one item per cycle while the receiver takes results; the per-motor entry update
// and report mux sit in one stage. The input register takes an item while a result waits,
// so a stalled result does not at once hold off the next request. Reset (synchronous, active
// high) clears every motor entry, empties both stages and sets the timeout register to 200 ms.
module motor_feedback_multiturn_tracker_unit
   import mft_pkg::*;
#(
   parameter int NUM_MOTORS = DEFAULT_NUM_MOTORS
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: now_ms[31:0], can_id[10:0], byte0..byte5 [7:0] each,
   // read_index[1:0], zero fill
   input  logic [95:0] req_tdata,
   // tuser: opcode
   input  logic        req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: motor_index[1:0], position_raw[15:0], motor_speed[15:0],
   // motor_current[15:0], position_total[31:0], online_mask[3:0], zero fill
   output logic [87:0] rsp_tdata,
   // tuser: frame_taken
   output logic        rsp_tuser,
   // Configuration: timeout_ms.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff;
   logic [31:0] in_now_ff;
   logic [10:0] in_id_ff;
   logic [47:0] in_bytes_ff;
   logic [1:0]  in_ridx_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_taken_ff, out_taken_in;
   logic [1:0]  out_index_ff, out_index_in;
   logic [15:0] out_pos_ff, out_pos_in;
   logic [15:0] out_speed_ff, out_speed_in;
   logic [15:0] out_current_ff, out_current_in;
   logic [31:0] out_total_ff, out_total_in;
   logic [3:0]  out_mask_ff, out_mask_in;

   logic [15:0] timeout_ff;

   logic          req_accept;
   logic          fire;
   logic [10:0]   id_offset;
   logic          frame_op;
   logic          check_op;
   logic          any_hit;
   slot_cmd_type  cmd_base;
   slot_cmd_type  cmds  [NUM_MOTORS];
   slot_view_type views [NUM_MOTORS];
   logic [NUM_MOTORS-1:0] frame_sel;
   logic [NUM_MOTORS-1:0] report_sel;

   // Handshake: the input register drains into the result register when there is room.
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || !out_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // Input item register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff    <= req_tuser;
         in_now_ff   <= req_tdata[31:0];
         in_id_ff    <= req_tdata[42:32];
         in_bytes_ff <= req_tdata[90:43];
         in_ridx_ff  <= req_tdata[92:91];
      end
   end

   // Decode of the item held in the input register.
   assign frame_op  = fire && (in_op_ff == OP_FRAME);
   assign check_op  = fire && (in_op_ff == OP_CHECK);
   assign id_offset = in_id_ff - ID_BASE;

   // Frame bytes are big-endian: byte0 high, byte1 low, and so on.
   always_comb begin
      cmd_base           = '0;
      cmd_base.check     = check_op;
      cmd_base.now_ms    = in_now_ff;
      cmd_base.position  = {in_bytes_ff[7:0],   in_bytes_ff[15:8]};
      cmd_base.speed     = {in_bytes_ff[23:16], in_bytes_ff[31:24]};
      cmd_base.current   = {in_bytes_ff[39:32], in_bytes_ff[47:40]};
   end

   // One slot per motor; each sees the command with its own frame match.
   for (genvar k = 0; k < NUM_MOTORS; k++) begin : g_slot
      assign frame_sel[k]  = in_id_ff == (ID_BASE + 11'(k));
      assign report_sel[k] = (in_op_ff == OP_FRAME) ? frame_sel[k] :
                             ({30'd0, in_ridx_ff} == 32'(k));

      always_comb begin
         cmds[k]           = cmd_base;
         cmds[k].frame_hit = frame_op && frame_sel[k];
      end

      mft_motor_slot u_slot (
         .clock      (clock),
         .reset      (reset),
         .apply      (fire),
         .cmd        (cmds[k]),
         .timeout_ms (timeout_ff),
         .view       (views[k])
      );
   end

   assign any_hit = |frame_sel;

   // Report: the matched or requested entry, or zeros where none applies.
   always_comb begin
      out_taken_in   = (in_op_ff == OP_FRAME) && any_hit;
      out_index_in   = 2'd0;
      out_pos_in     = 16'd0;
      out_speed_in   = 16'd0;
      out_current_in = 16'd0;
      out_total_in   = 32'd0;
      out_mask_in    = 4'd0;
      if (in_op_ff == OP_CHECK) begin
         out_index_in = in_ridx_ff;
      end else if (any_hit) begin
         out_index_in = id_offset[1:0];
      end
      for (int k = 0; k < NUM_MOTORS; k++) begin
         if (report_sel[k]) begin
            out_pos_in     = out_pos_in     | views[k].position;
            out_speed_in   = out_speed_in   | views[k].speed;
            out_current_in = out_current_in | views[k].current;
            out_total_in   = out_total_in   | views[k].total;
         end
         if (k < 4) begin
            out_mask_in[k] = views[k].online;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_taken_ff   <= out_taken_in;
         out_index_ff   <= out_index_in;
         out_pos_ff     <= out_pos_in;
         out_speed_ff   <= out_speed_in;
         out_current_ff <= out_current_in;
         out_total_ff   <= out_total_in;
         out_mask_ff    <= out_mask_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_taken_ff;
   assign rsp_tdata  = {2'd0, out_mask_ff, out_total_ff, out_current_ff,
                        out_speed_ff, out_pos_ff, out_index_ff};

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mft_pkg::*;

   localparam int NUM_TRACKED = DEFAULT_NUM_MOTORS;
   localparam int NUM_DIRECTED = 23;
   localparam int ITEMS_PER_PHASE = 345;

   // One request item, with the frame bytes kept as big-endian halfwords.
   typedef struct packed {
      logic        opcode;
      logic [31:0] now_ms;
      logic [10:0] can_id;
      logic [15:0] position;
      logic [15:0] speed;
      logic [15:0] current;
      logic [1:0]  read_index;
   } feedback_req_type;

   // One result item, field by field.
   typedef struct packed {
      logic               frame_taken;
      logic [1:0]         motor_index;
      logic [15:0]        position_raw;
      logic signed [15:0] motor_speed;
      logic signed [15:0] motor_current;
      logic signed [31:0] position_total;
      logic [3:0]         online_mask;
   } feedback_report_type;

   // Directed row: a request, and a result typed in where it is obvious.
   typedef struct packed {
      feedback_req_type    req;
      logic                typed;
      feedback_report_type want;
   } feedback_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Tracker state as the block should hold it.
   logic [15:0] last_pos_q [NUM_TRACKED];
   logic [31:0] turns_q [NUM_TRACKED];
   logic [31:0] seen_ms_q [NUM_TRACKED];
   logic        online_q [NUM_TRACKED];
   logic [15:0] speed_q [NUM_TRACKED];
   logic [15:0] current_q [NUM_TRACKED];
   logic [31:0] total_q [NUM_TRACKED];
   logic [15:0] timeout_q;

   feedback_report_type pending_reports [$];
   feedback_row_type    dir_rows [NUM_DIRECTED];

   int          error_count = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic [31:0] stamp_ms = '0;
   int          frames_taken = 0;
   int          frames_unknown = 0;
   int          checks_done = 0;
   int          dropouts = 0;
   int          turn_steps = 0;

   motor_feedback_multiturn_tracker_unit #(
      .NUM_MOTORS(NUM_TRACKED)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 40) begin
         $display("mismatch on %0s at %0t ns: got %0d, expected %0d", what, $time, got, want);
      end
   endtask

   function automatic feedback_req_type request(input logic op, input logic [31:0] now,
                                                input logic [10:0] id, input logic [15:0] pos,
                                                input logic [15:0] spd, input logic [15:0] cur,
                                                input logic [1:0] ridx);
      feedback_req_type rq;
      rq.opcode = op;
      rq.now_ms = now;
      rq.can_id = id;
      rq.position = pos;
      rq.speed = spd;
      rq.current = cur;
      rq.read_index = ridx;
      return rq;
   endfunction

   // Applies one item to the tracker state and returns the entry it reports.
   function automatic feedback_report_type track_feedback(input feedback_req_type rq);
      feedback_report_type rep;
      int                  slot;
      int                  diff;
      logic                show;
      logic [31:0]         age;
      rep = '0;
      show = 1'b0;
      slot = 0;
      if (rq.opcode == OP_FRAME) begin
         if (rq.can_id >= ID_BASE && int'(rq.can_id) < int'(ID_BASE) + NUM_TRACKED) begin
            slot = int'(rq.can_id - ID_BASE);
            speed_q[slot] = rq.speed;
            current_q[slot] = rq.current;
            online_q[slot] = 1'b1;
            seen_ms_q[slot] = rq.now_ms;
            // A jump of more than half a turn means the encoder wrapped.
            diff = int'(rq.position) - int'(last_pos_q[slot]);
            if (diff > int'(HALF_TURN)) begin
               turns_q[slot] = turns_q[slot] - 32'd1;
               turn_steps++;
            end else if (diff < -int'(HALF_TURN)) begin
               turns_q[slot] = turns_q[slot] + 32'd1;
               turn_steps++;
            end
            last_pos_q[slot] = rq.position;
            total_q[slot] = (turns_q[slot] << TURN_SHIFT) + {16'd0, rq.position};
            rep.frame_taken = 1'b1;
            show = 1'b1;
            frames_taken++;
         end else begin
            frames_unknown++;
         end
      end else begin
         // Age every motor, the wrap of the millisecond counter included.
         for (int k = 0; k < NUM_TRACKED; k++) begin
            age = rq.now_ms - seen_ms_q[k];
            if (age > {16'd0, timeout_q}) begin
               if (online_q[k]) dropouts++;
               online_q[k] = 1'b0;
               speed_q[k] = '0;
            end
         end
         slot = int'(rq.read_index);
         rep.motor_index = rq.read_index;
         show = 1'b1;
         checks_done++;
      end
      if (show && slot < NUM_TRACKED) begin
         rep.motor_index = slot[1:0];
         rep.position_raw = last_pos_q[slot];
         rep.motor_speed = speed_q[slot];
         rep.motor_current = current_q[slot];
         rep.position_total = total_q[slot];
      end
      for (int k = 0; k < NUM_TRACKED && k < 4; k++) begin
         rep.online_mask[k] = online_q[k];
      end
      return rep;
   endfunction

   // Random item: mostly frames from known motors with a plausible position walk.
   function automatic feedback_req_type make_random_item();
      feedback_req_type rq;
      int               pick;
      int               step;
      logic [1:0]       motor;
      case ($urandom_range(0, 9))
         0: stamp_ms = $urandom();
         1, 2: stamp_ms = stamp_ms + $urandom_range(0, 70000);
         default: stamp_ms = stamp_ms + $urandom_range(0, 120);
      endcase
      motor = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: step = $urandom_range(0, 65535);
         1: begin
            step = int'(HALF_TURN) - 3 + $urandom_range(0, 6);
            if ($urandom_range(0, 1) == 1) step = -step;
         end
         default: step = $urandom_range(0, 600) - 300;
      endcase
      rq.opcode = OP_FRAME;
      rq.now_ms = stamp_ms;
      rq.can_id = ID_BASE + motor;
      rq.position = last_pos_q[motor] + step[15:0];
      rq.speed = 16'($urandom());
      rq.current = 16'($urandom());
      rq.read_index = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         rq.opcode = OP_CHECK;
         rq.can_id = 11'($urandom_range(0, 2047));
      end else if (pick < 37) begin
         rq.can_id = 11'($urandom_range(0, 2047));
      end
      return rq;
   endfunction

   // Presents one item, with random gaps before it, and waits for it to be taken.
   task automatic drive_request(input feedback_req_type rq);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.opcode;
      req_tdata <= {3'b000, rq.read_index, rq.current[7:0], rq.current[15:8],
                    rq.speed[7:0], rq.speed[15:8], rq.position[7:0], rq.position[15:8],
                    rq.can_id, rq.now_ms};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      timeout_q = value;
   endtask

   // Each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      feedback_report_type got;
      feedback_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.frame_taken = rsp_tuser;
         got.motor_index = rsp_tdata[1:0];
         got.position_raw = rsp_tdata[17:2];
         got.motor_speed = rsp_tdata[33:18];
         got.motor_current = rsp_tdata[49:34];
         got.position_total = rsp_tdata[81:50];
         got.online_mask = rsp_tdata[85:82];
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected result item", got.position_total, 0);
         end else begin
            want = pending_reports.pop_front();
            if (got.frame_taken !== want.frame_taken)
               report_mismatch("frame_taken", got.frame_taken, want.frame_taken);
            if (got.motor_index !== want.motor_index)
               report_mismatch("motor_index", got.motor_index, want.motor_index);
            if (got.position_raw !== want.position_raw)
               report_mismatch("position_raw", got.position_raw, want.position_raw);
            if (got.motor_speed !== want.motor_speed)
               report_mismatch("motor_speed", got.motor_speed, want.motor_speed);
            if (got.motor_current !== want.motor_current)
               report_mismatch("motor_current", got.motor_current, want.motor_current);
            if (got.position_total !== want.position_total)
               report_mismatch("position_total", got.position_total, want.position_total);
            if (got.online_mask !== want.online_mask)
               report_mismatch("online_mask", got.online_mask, want.online_mask);
         end
      end
   end

   // Main sequence: reset, directed table, then three randomised phases.
   initial begin : main_flow
      feedback_req_type    rq;
      feedback_report_type predicted;
      logic [15:0]         mid_timeout;

      for (int k = 0; k < NUM_TRACKED; k++) begin
         last_pos_q[k] = '0;
         turns_q[k] = '0;
         seen_ms_q[k] = '0;
         online_q[k] = 1'b0;
         speed_q[k] = '0;
         current_q[k] = '0;
         total_q[k] = '0;
      end
      timeout_q = TIMEOUT_RESET;
      tx_idle_pct = 28;
      rx_idle_pct = 57;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, run with the timeout at its reset value.
      // Nothing seen yet: a check reports an empty entry and no motor online.
      dir_rows[0] = '{req: request(OP_CHECK, 32'd0, 11'h000, 16'h0000, 16'h0000, 16'h0000,
                                   2'd0), typed: 1'b1, want: '0};
      // Identifiers outside the motor range leave everything untouched.
      dir_rows[1] = '{req: request(OP_FRAME, 32'd5, 11'h200, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   2'd3), typed: 1'b1, want: '0};
      dir_rows[2] = '{req: request(OP_FRAME, 32'd6, 11'h205, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   2'd3), typed: 1'b1, want: '0};
      dir_rows[3] = '{req: request(OP_FRAME, 32'hFFFFFFFF, 11'h7FF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 2'd3), typed: 1'b1, want: '0};
      dir_rows[4] = '{req: request(OP_FRAME, 32'd7, 11'h000, 16'h0000, 16'h0000, 16'h0000,
                                   2'd0), typed: 1'b1, want: '0};
      // First frame of motor 0 with extreme speed and current.
      dir_rows[5] = '{req: request(OP_FRAME, 32'd100, 11'h201, 16'h0000, 16'h7FFF, 16'h8000,
                                   2'd0), typed: 1'b1,
                      want: '{frame_taken: 1'b1, motor_index: 2'd0, position_raw: 16'h0000,
                              motor_speed: 16'sh7FFF, motor_current: 16'sh8000,
                              position_total: 32'sd0, online_mask: 4'b0001}};
      // A jump to the top of the range counts one turn down, from zero.
      dir_rows[6] = '{req: request(OP_FRAME, 32'd110, 11'h204, 16'hFFFF, 16'h8000, 16'h7FFF,
                                   2'd0), typed: 1'b0, want: '0};
      // Exactly half a turn either way is not a wrap; one count more is.
      dir_rows[7] = '{req: request(OP_FRAME, 32'd120, 11'h202, 16'h1000, 16'h0001, 16'h0002,
                                   2'd0), typed: 1'b0, want: '0};
      dir_rows[8] = '{req: request(OP_FRAME, 32'd130, 11'h202, 16'h0000, 16'h0003, 16'h0004,
                                   2'd0), typed: 1'b0, want: '0};
      dir_rows[9] = '{req: request(OP_FRAME, 32'd140, 11'h202, 16'h1001, 16'h0005, 16'h0006,
                                   2'd0), typed: 1'b0, want: '0};
      dir_rows[10] = '{req: request(OP_FRAME, 32'd150, 11'h202, 16'h0000, 16'hFFF0, 16'h00F0,
                                    2'd0), typed: 1'b0, want: '0};
      // Encoder wrap within one 8192 count turn, forwards and back.
      dir_rows[11] = '{req: request(OP_FRAME, 32'd160, 11'h203, 16'h1FFF, 16'h1234, 16'h5678,
                                    2'd0), typed: 1'b0, want: '0};
      dir_rows[12] = '{req: request(OP_FRAME, 32'd170, 11'h203, 16'h0000, 16'h1234, 16'h5678,
                                    2'd0), typed: 1'b0, want: '0};
      dir_rows[13] = '{req: request(OP_FRAME, 32'd180, 11'h203, 16'h1FFF, 16'h1234, 16'h5678,
                                    2'd0), typed: 1'b0, want: '0};
      dir_rows[14] = '{req: request(OP_FRAME, 32'd190, 11'h203, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    2'd0), typed: 1'b0, want: '0};
      // Motor 0 at an age of exactly the timeout stays online; one more ms drops it.
      dir_rows[15] = '{req: request(OP_CHECK, 32'd300, 11'h201, 16'h0000, 16'h0000, 16'h0000,
                                    2'd0), typed: 1'b0, want: '0};
      dir_rows[16] = '{req: request(OP_CHECK, 32'd301, 11'h201, 16'h0000, 16'h0000, 16'h0000,
                                    2'd0), typed: 1'b0, want: '0};
      dir_rows[17] = '{req: request(OP_CHECK, 32'd301, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    2'd3), typed: 1'b0, want: '0};
      // Ageing across the wrap of the millisecond counter.
      dir_rows[18] = '{req: request(OP_FRAME, 32'hFFFFFFF0, 11'h202, 16'h1234, 16'h0100,
                                    16'hFF00, 2'd1), typed: 1'b0, want: '0};
      dir_rows[19] = '{req: request(OP_CHECK, 32'h00000010, 11'h000, 16'h0000, 16'h0000,
                                    16'h0000, 2'd1), typed: 1'b0, want: '0};
      dir_rows[20] = '{req: request(OP_CHECK, 32'h000000D8, 11'h000, 16'h0000, 16'h0000,
                                    16'h0000, 2'd1), typed: 1'b0, want: '0};
      dir_rows[21] = '{req: request(OP_FRAME, 32'd0, 11'h201, 16'h0000, 16'h0000, 16'h0000,
                                    2'd0), typed: 1'b0, want: '0};
      // A check ignores the frame fields it carries.
      dir_rows[22] = '{req: request(OP_CHECK, 32'd5, 11'h201, 16'hA5A5, 16'h5A5A, 16'hC3C3,
                                    2'd2), typed: 1'b0, want: '0};

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         drive_request(dir_rows[i].req);
         predicted = track_feedback(dir_rows[i].req);
         pending_reports.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
      end

      // Random phases, each with its own idling pattern and timeout.
      mid_timeout = 16'($urandom_range(1, 1000));
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 28;
               rx_idle_pct = 57;
               set_timeout(mid_timeout);
            end
            1: begin
               tx_idle_pct = 57;
               rx_idle_pct = 28;
               set_timeout(16'd0);
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               set_timeout(16'hFFFF);
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, let the block run completely dry once.
            if (n == ITEMS_PER_PHASE / 2) drain_results();
            rq = make_random_item();
            drive_request(rq);
            pending_reports.push_back(track_feedback(rq));
         end
      end

      drain_results();
      repeat (10) @(posedge clock);

      $display("Covered %0d frames taken, %0d unknown identifiers, %0d checks",
               frames_taken, frames_unknown, checks_done);
      $display("with %0d turn steps and %0d motors timed out; timeouts 200, %0d, 0 and 65535 ms",
               turn_steps, dropouts, mid_timeout);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("[motor_feedback_multiturn_tracker_unit] OK");
      end else begin
         $display("[motor_feedback_multiturn_tracker_unit] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5000000;
      $display("timed out with %0d results outstanding", pending_reports.size());
      $display("[motor_feedback_multiturn_tracker_unit] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mft_pkg.sv
rtl/mft_motor_slot.sv
rtl/motor_feedback_multiturn_tracker_unit.sv
test/testbench.sv
